FILE: rtl/f24ma_pkg.sv
// package: word types and constants for the 24-bit float multiply-add unit
`timescale 1ns / 1ps
`default_nettype none

package f24ma_pkg;

    localparam int MANT_W  = 16;
    localparam int EXP_W   = 8;
    localparam int RAW_W   = 32;
    localparam int EXPX_W  = 10;
    localparam int SHIFT_W = 5;

    localparam logic FUNC_MUL = 1'b0;
    localparam logic FUNC_ADD = 1'b1;

    typedef struct packed {
        logic                       func;
        logic signed [MANT_W-1:0]   a_mantissa;
        logic signed [EXP_W-1:0]    a_exponent;
        logic signed [MANT_W-1:0]   b_mantissa;
        logic signed [EXP_W-1:0]    b_exponent;
    } in_word_t;

    typedef struct packed {
        logic signed [MANT_W-1:0]   res_mantissa;
        logic signed [EXP_W-1:0]    res_exponent;
        logic                       exp_overflow;
    } out_word_t;

    typedef struct packed {
        logic signed [RAW_W-1:0]    m;
        logic signed [EXPX_W-1:0]   e;
    } raw_t;

endpackage

`default_nettype wire

FILE: rtl/f24ma_norm.sv
// normalise pipeline: leading-one count, then shift, sign and exponent wrap
`timescale 1ns / 1ps
`default_nettype none

module f24ma_norm (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             in_valid,
    output logic                  in_ready,
    input  wire f24ma_pkg::raw_t  in_raw,
    output logic                  out_valid,
    input  wire logic             out_ready,
    output f24ma_pkg::out_word_t  out_word
);
    import f24ma_pkg::*;

    logic                   n3_valid_reg;
    logic                   n3_neg_reg;
    logic [RAW_W-2:0]       n3_mag_reg;
    logic [SHIFT_W-1:0]     n3_shift_reg;
    logic signed [EXPX_W-1:0] n3_exp_reg;
    logic                   n3_ready;

    logic                   out_valid_reg;
    out_word_t              out_word_reg;
    logic                   out_stage_ready;

    logic                   neg_next;
    logic [RAW_W-1:0]       abs_full;
    logic [RAW_W-2:0]       mag_next;
    logic [SHIFT_W-1:0]     shift_next;

    logic [RAW_W-2:0]       quot;
    logic [MANT_W-1:0]      mant_next;
    logic signed [EXPX_W-1:0] exp_next;
    logic                   ovf_next;

    assign out_stage_ready = !out_valid_reg || out_ready;
    assign n3_ready        = !n3_valid_reg || out_stage_ready;
    assign in_ready        = n3_ready;

    // magnitude and halving count
    always_comb begin
        neg_next   = in_raw.m[RAW_W-1];
        abs_full   = neg_next ? (RAW_W'(0) - RAW_W'(in_raw.m)) : RAW_W'(in_raw.m);
        mag_next   = abs_full[RAW_W-2:0];
        shift_next = '0;
        for (int i = MANT_W - 1; i <= RAW_W - 2; i++) begin
            if (mag_next[i]) begin
                shift_next = SHIFT_W'(i - (MANT_W - 2));
            end
        end
    end

    // shift, restore sign, wrap exponent
    always_comb begin
        quot      = (RAW_W-1)'(n3_mag_reg >> n3_shift_reg);
        mant_next = n3_neg_reg ? (MANT_W'(0) - quot[MANT_W-1:0]) : quot[MANT_W-1:0];
        exp_next  = n3_exp_reg + $signed({{(EXPX_W-SHIFT_W){1'b0}}, n3_shift_reg});
        ovf_next  = (exp_next < -EXPX_W'(128)) || (exp_next > EXPX_W'(127));
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            n3_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (n3_ready) begin
                n3_valid_reg <= in_valid;
            end
            if (out_stage_ready) begin
                out_valid_reg <= n3_valid_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (n3_ready && in_valid) begin
            n3_neg_reg   <= neg_next;
            n3_mag_reg   <= mag_next;
            n3_shift_reg <= shift_next;
            n3_exp_reg   <= in_raw.e;
        end
        if (out_stage_ready && n3_valid_reg) begin
            out_word_reg.res_mantissa <= mant_next;
            out_word_reg.res_exponent <= exp_next[EXP_W-1:0];
            out_word_reg.exp_overflow <= ovf_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_word  = out_word_reg;

endmodule

`default_nettype wire

FILE: rtl/float24_mul_add_unit.sv
// top level: multiply or add of two 24-bit floats with normalised result
//
// input channel s_valid / s_ready / s_word carries func and two operands
// (16-bit signed mantissa, 8-bit signed exponent each); func selects
// multiply or add. output channel m_valid / m_ready / m_word carries the
// normalised mantissa, the exponent wrapped to 8 bits and an overflow flag
// for the true exponent. one result word per input word, in order.
// four register stages: product and alignment, raw sum select,
// leading-one count, shift and exponent wrap. m_valid is driven by the
// last of the four; throughput is one word per cycle while m_ready is
// high, as every stage can take a new word each cycle.
// each stage moves when the one after it is empty or moving, so a stall
// on m_ready backs up through the stages and drops s_ready only once all
// four are full; nothing is lost or repeated.
// synchronous active-low reset empties every stage; s_ready is high in
// the first cycle after reset.
`timescale 1ns / 1ps
`default_nettype none

module float24_mul_add_unit (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_valid,
    output logic                      s_ready,
    input  wire f24ma_pkg::in_word_t  s_word,
    output logic                      m_valid,
    input  wire logic                 m_ready,
    output f24ma_pkg::out_word_t      m_word
);
    import f24ma_pkg::*;

    localparam int MAG_W = MANT_W + 1;
    localparam int SUM_W = MANT_W + 2;

    // stage 1 registers
    logic                       st1_valid_reg;
    logic                       st1_func_reg;
    logic signed [RAW_W-1:0]    st1_prod_reg;
    logic                       st1_neg_a_reg;
    logic                       st1_neg_b_reg;
    logic [MAG_W-1:0]           st1_mag_a_reg;
    logic [MAG_W-1:0]           st1_mag_b_reg;
    logic [SHIFT_W-1:0]         st1_sh_a_reg;
    logic [SHIFT_W-1:0]         st1_sh_b_reg;
    logic [EXP_W-1:0]           st1_emax_reg;
    logic [EXP_W:0]             st1_esum_reg;
    logic                       st1_ready;

    // stage 2 registers
    logic                       st2_valid_reg;
    raw_t                       st2_raw_reg;
    logic                       st2_ready;

    logic                       norm_ready;

    // stage 1 logic
    logic signed [RAW_W-1:0]    prod_next;
    logic [EXP_W-1:0]           emax_next;
    logic [EXP_W:0]             esum_next;
    logic [EXP_W:0]             diff_a;
    logic [EXP_W:0]             diff_b;
    logic [SHIFT_W-1:0]         sh_a_next;
    logic [SHIFT_W-1:0]         sh_b_next;
    logic [MAG_W-1:0]           mag_a_next;
    logic [MAG_W-1:0]           mag_b_next;

    // stage 2 logic
    logic [MAG_W-1:0]           ta;
    logic [MAG_W-1:0]           tb;
    logic [SUM_W-1:0]           va;
    logic [SUM_W-1:0]           vb;
    logic [SUM_W-1:0]           sum;
    raw_t                       raw_next;

    assign st2_ready = !st2_valid_reg || norm_ready;
    assign st1_ready = !st1_valid_reg || st2_ready;
    assign s_ready   = st1_ready;

    always_comb begin
        prod_next = $signed(s_word.a_mantissa) * $signed(s_word.b_mantissa);
        emax_next = ($signed(s_word.a_exponent) > $signed(s_word.b_exponent)) ?
                    s_word.a_exponent : s_word.b_exponent;
        esum_next = {s_word.a_exponent[EXP_W-1], s_word.a_exponent}
                  + {s_word.b_exponent[EXP_W-1], s_word.b_exponent};
        diff_a    = {emax_next[EXP_W-1], emax_next}
                  - {s_word.a_exponent[EXP_W-1], s_word.a_exponent};
        diff_b    = {emax_next[EXP_W-1], emax_next}
                  - {s_word.b_exponent[EXP_W-1], s_word.b_exponent};
        sh_a_next = (diff_a >= (EXP_W+1)'(MANT_W)) ? SHIFT_W'(MANT_W)
                                                   : SHIFT_W'(diff_a[SHIFT_W-2:0]);
        sh_b_next = (diff_b >= (EXP_W+1)'(MANT_W)) ? SHIFT_W'(MANT_W)
                                                   : SHIFT_W'(diff_b[SHIFT_W-2:0]);
        mag_a_next = s_word.a_mantissa[MANT_W-1] ?
                     (MAG_W'(0) - {1'b1, s_word.a_mantissa}) : {1'b0, s_word.a_mantissa};
        mag_b_next = s_word.b_mantissa[MANT_W-1] ?
                     (MAG_W'(0) - {1'b1, s_word.b_mantissa}) : {1'b0, s_word.b_mantissa};
    end

    // aligned add, or pass the product
    always_comb begin
        ta  = st1_mag_a_reg >> st1_sh_a_reg;
        tb  = st1_mag_b_reg >> st1_sh_b_reg;
        va  = st1_neg_a_reg ? (SUM_W'(0) - {1'b0, ta}) : {1'b0, ta};
        vb  = st1_neg_b_reg ? (SUM_W'(0) - {1'b0, tb}) : {1'b0, tb};
        sum = va + vb;
        case (st1_func_reg)
            FUNC_MUL: begin
                raw_next.m = st1_prod_reg;
                raw_next.e = {st1_esum_reg[EXP_W], st1_esum_reg};
            end
            default: begin
                raw_next.m = {{(RAW_W-SUM_W){sum[SUM_W-1]}}, sum};
                raw_next.e = {{(EXPX_W-EXP_W){st1_emax_reg[EXP_W-1]}}, st1_emax_reg};
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st1_valid_reg <= 1'b0;
            st2_valid_reg <= 1'b0;
        end else begin
            if (st1_ready) begin
                st1_valid_reg <= s_valid;
            end
            if (st2_ready) begin
                st2_valid_reg <= st1_valid_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (st1_ready && s_valid) begin
            st1_func_reg  <= s_word.func;
            st1_prod_reg  <= prod_next;
            st1_neg_a_reg <= s_word.a_mantissa[MANT_W-1];
            st1_neg_b_reg <= s_word.b_mantissa[MANT_W-1];
            st1_mag_a_reg <= mag_a_next;
            st1_mag_b_reg <= mag_b_next;
            st1_sh_a_reg  <= sh_a_next;
            st1_sh_b_reg  <= sh_b_next;
            st1_emax_reg  <= emax_next;
            st1_esum_reg  <= esum_next;
        end
        if (st2_ready && st1_valid_reg) begin
            st2_raw_reg <= raw_next;
        end
    end

    f24ma_norm u_norm (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (st2_valid_reg),
        .in_ready  (norm_ready),
        .in_raw    (st2_raw_reg),
        .out_valid (m_valid),
        .out_ready (m_ready),
        .out_word  (m_word)
    );

    // a ready receiver never stalls the input
    a_no_stall_when_drained: assert property (@(posedge aclk) disable iff (!aresetn)
        m_ready |-> s_ready)
        else $error("input stalled while output drains");

    // halving always leaves the mantissa above the most negative code
    a_mant_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_word.res_mantissa != 16'sh8000))
        else $error("unnormalised mantissa on output");

    // reset empties the output stage
    a_reset_empties: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("output valid after reset");

endmodule

`default_nettype wire

FILE: tb/sv/f24ma_result_checker.sv
// checker: predicts each result word of the 24-bit float multiply-add unit and compares
`timescale 1ns / 1ps
`default_nettype none

module f24ma_result_checker (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_valid,
    input  wire logic                 s_ready,
    input  wire f24ma_pkg::in_word_t  s_word,
    input  wire logic                 m_valid,
    input  wire logic                 m_ready,
    input  wire f24ma_pkg::out_word_t m_word,
    output int                        errors,
    output int                        pending,
    output int                        checked,
    output int                        overflows
);

    import f24ma_pkg::*;

    localparam int MANT_MAX = 32767;
    localparam int MANT_MIN = -32768;
    localparam int EXP_MAX  = 127;
    localparam int EXP_MIN  = -128;
    localparam int REPORT_LIMIT = 10;

    out_word_t expected_words[$];

    initial begin
        errors    = 0;
        pending   = 0;
        checked   = 0;
        overflows = 0;
    end

    // divide by a power of two, rounding toward zero
    function automatic int shift_toward_zero(int m, int d);
        if (d >= MANT_W)
            return 0;
        if (m < 0)
            return -((-m) >>> d);
        return m >>> d;
    endfunction

    function automatic out_word_t predict_result(in_word_t w);
        int am, ae, bm, be;
        int raw, ex;
        out_word_t r;
        am = $signed(w.a_mantissa);
        ae = $signed(w.a_exponent);
        bm = $signed(w.b_mantissa);
        be = $signed(w.b_exponent);
        if (w.func == FUNC_MUL) begin
            raw = am * bm;
            ex  = ae + be;
        end else begin
            ex  = (ae > be) ? ae : be;
            raw = shift_toward_zero(am, ex - ae) + shift_toward_zero(bm, ex - be);
        end
        while (raw > MANT_MAX) begin
            raw = raw / 2;
            ex++;
        end
        while (raw <= MANT_MIN) begin
            raw = raw / 2;
            ex++;
        end
        r.res_mantissa = raw[MANT_W-1:0];
        r.res_exponent = ex[EXP_W-1:0];
        r.exp_overflow = (ex < EXP_MIN) || (ex > EXP_MAX);
        return r;
    endfunction

    always @(posedge aclk) begin
        out_word_t want;
        if (!aresetn) begin
            expected_words.delete();
        end else begin
            if (m_valid && m_ready) begin
                if (expected_words.size() == 0) begin
                    errors++;
                    if (errors <= REPORT_LIMIT)
                        $display("unexpected result word: m=%0d e=%0d ovf=%0b",
                                 $signed(m_word.res_mantissa),
                                 $signed(m_word.res_exponent), m_word.exp_overflow);
                end else begin
                    want = expected_words.pop_front();
                    checked++;
                    if (want.exp_overflow)
                        overflows++;
                    if (m_word.res_mantissa !== want.res_mantissa ||
                        m_word.res_exponent !== want.res_exponent ||
                        m_word.exp_overflow !== want.exp_overflow) begin
                        errors++;
                        if (errors <= REPORT_LIMIT)
                            $display("mismatch on word %0d: expected m=%0d e=%0d ovf=%0b, got m=%0d e=%0d ovf=%0b",
                                     checked,
                                     $signed(want.res_mantissa),
                                     $signed(want.res_exponent), want.exp_overflow,
                                     $signed(m_word.res_mantissa),
                                     $signed(m_word.res_exponent), m_word.exp_overflow);
                    end
                end
            end
            if (s_valid && s_ready)
                expected_words.push_back(predict_result(s_word));
        end
        pending = expected_words.size();
    end

endmodule

`default_nettype wire

FILE: tb/sv/tb_float24_mul_add_unit.sv
// testbench top: stimulus, flow control and verdict for the 24-bit float multiply-add unit
`timescale 1ns / 1ps
`default_nettype none

module tb_float24_mul_add_unit;

    import f24ma_pkg::*;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int RESET_CYCLES = 9;
    localparam int PHASE_WORDS  = 150;
    localparam int HOLD_CYCLES  = 40;
    localparam int DRAIN_CYCLES = 8;

    logic      aclk    = 1'b0;
    logic      aresetn = 1'b0;
    logic      s_valid = 1'b0;
    logic      s_ready;
    in_word_t  s_word  = '0;
    logic      m_valid;
    logic      m_ready = 1'b0;
    out_word_t m_word;

    int errors, pending, checked, overflows;
    int tx_idle_pct = 0;
    int rx_idle_pct = 0;
    int hold_len    = 0;
    int sent        = 0;
    int cycles      = 0;

    always #5 aclk = ~aclk;

    float24_mul_add_unit dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_word  (s_word),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_word  (m_word)
    );

    f24ma_result_checker u_checker (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_word    (s_word),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_word    (m_word),
        .errors    (errors),
        .pending   (pending),
        .checked   (checked),
        .overflows (overflows)
    );

    initial begin
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
    end

    always @(posedge aclk) begin
        cycles++;
        if (cycles >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // result side, with an optional long hold-off
    initial begin
        forever begin
            @(posedge aclk);
            if (hold_len > 0) begin
                m_ready <= 1'b0;
                repeat (hold_len) @(posedge aclk);
                hold_len = 0;
            end else begin
                m_ready <= ($urandom_range(99) >= rx_idle_pct);
            end
        end
    end

    function automatic in_word_t make_word(logic f, int am, int ae, int bm, int be);
        in_word_t w;
        w.func       = f;
        w.a_mantissa = 16'(am);
        w.a_exponent = 8'(ae);
        w.b_mantissa = 16'(bm);
        w.b_exponent = 8'(be);
        return w;
    endfunction

    function automatic logic signed [MANT_W-1:0] pick_mantissa();
        int v;
        case ($urandom_range(5))
            0: v = -32768;
            1: v = 32767;
            2: v = int'($urandom_range(16)) - 8;
            3: v = int'($urandom_range(511)) - 256;
            default: v = int'($urandom);
        endcase
        return 16'(v);
    endfunction

    function automatic logic signed [EXP_W-1:0] pick_exponent();
        int v;
        case ($urandom_range(3))
            0: v = 127 - int'($urandom_range(7));
            1: v = -128 + int'($urandom_range(7));
            2: v = int'($urandom_range(20)) - 10;
            default: v = int'($urandom);
        endcase
        return 8'(v);
    endfunction

    function automatic in_word_t random_word();
        in_word_t w;
        int diff;
        w.func       = $urandom_range(1) ? FUNC_ADD : FUNC_MUL;
        w.a_mantissa = pick_mantissa();
        w.a_exponent = pick_exponent();
        w.b_mantissa = pick_mantissa();
        w.b_exponent = pick_exponent();
        // keep many adds near the alignment boundary
        if ($urandom_range(2) == 0) begin
            diff = int'($urandom_range(40)) - 20;
            w.b_exponent = 8'(int'($signed(w.a_exponent)) + diff);
        end
        return w;
    endfunction

    task automatic send_word(input in_word_t w);
        while ($urandom_range(99) < tx_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_word  <= w;
        do @(posedge aclk); while (!s_ready);
        sent++;
    endtask

    initial begin
        do @(posedge aclk); while (!aresetn);

        tx_idle_pct = 19;
        rx_idle_pct = 62;

        // products at the mantissa extremes
        send_word(make_word(FUNC_MUL, 32767, 0, 32767, 0));
        send_word(make_word(FUNC_MUL, -32768, 0, -32768, 0));
        send_word(make_word(FUNC_MUL, -32768, 3, 1, 0));
        send_word(make_word(FUNC_MUL, -32768, 0, 32767, 0));
        send_word(make_word(FUNC_MUL, 32767, 5, 1, -5));
        send_word(make_word(FUNC_MUL, 0, 0, 0, 0));
        send_word(make_word(FUNC_MUL, -3, 0, 21846, 0));
        // exponent wrap on multiply
        send_word(make_word(FUNC_MUL, 1, 127, 1, 0));
        send_word(make_word(FUNC_MUL, 1, 127, 1, 127));
        send_word(make_word(FUNC_MUL, -1, -128, 1, -128));
        send_word(make_word(FUNC_MUL, 32767, 127, 2, 0));
        send_word(make_word(FUNC_MUL, -32768, -128, -32768, 0));
        // sums at the extremes
        send_word(make_word(FUNC_ADD, 32767, 127, 32767, 127));
        send_word(make_word(FUNC_ADD, -32768, -128, -32768, -128));
        send_word(make_word(FUNC_ADD, -16384, 0, -16384, 0));
        send_word(make_word(FUNC_ADD, 0, 0, 0, 0));
        // alignment: dropped operand and truncation toward zero
        send_word(make_word(FUNC_ADD, 1000, 20, 5, 0));
        send_word(make_word(FUNC_ADD, 32767, 15, -32768, 0));
        send_word(make_word(FUNC_ADD, -32768, 16, 1234, 0));
        send_word(make_word(FUNC_ADD, 7, 0, -32768, 16));
        send_word(make_word(FUNC_ADD, -1, 5, -1, 0));
        send_word(make_word(FUNC_ADD, -3, 0, -32768, 1));
        send_word(make_word(FUNC_ADD, 32767, -128, -32768, 127));
        send_word(make_word(FUNC_ADD, -32768, 127, 32767, -128));

        repeat (PHASE_WORDS) send_word(random_word());

        tx_idle_pct = 62;
        rx_idle_pct = 19;
        repeat (PHASE_WORDS) send_word(random_word());

        tx_idle_pct = 0;
        rx_idle_pct = 0;
        hold_len    = HOLD_CYCLES;
        repeat (PHASE_WORDS) send_word(random_word());

        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("sent %0d words, directed extremes then random multiply and add", sent);
        $display("under three flow-control mixes and a long output stall");
        $display("%0d results checked, %0d with exponent overflow", checked, overflows);
        if (errors == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("%0d errors", errors);
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

`default_nettype wire

FILE: filelist.f
rtl/f24ma_pkg.sv
rtl/f24ma_norm.sv
rtl/float24_mul_add_unit.sv
tb/sv/f24ma_result_checker.sv
tb/sv/tb_float24_mul_add_unit.sv
